// File: src/rtps_pkg.sv
`default_nettype none
package rtps_pkg;

	localparam int WIDTH_DEF = 16;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture bounds, start at lower
		logic emit_block;  // register the current block, advance start
		logic emit_err;    // register the error beat
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;   // start past upper: only seen right after load when upper < lower
		logic last;  // current block ends exactly at upper
	} status_t;

endpackage
`default_nettype wire

// File: src/rtps_dp.sv
`default_nettype none
module rtps_dp #(
	parameter int WIDTH = rtps_pkg::WIDTH_DEF
) (
	input  wire                   clk,
	input  wire  [WIDTH-1:0]      lower_bound,
	input  wire  [WIDTH-1:0]      upper_bound,
	input  wire  rtps_pkg::cmd_t  cmd,
	output rtps_pkg::status_t     status,
	output logic [WIDTH-1:0]      base_value,
	output logic [WIDTH-1:0]      dont_care_mask,
	output logic                  last_block,
	output logic                  range_error
);

	logic [WIDTH:0]   start_q;
	logic [WIDTH-1:0] upper_q;
	logic [WIDTH-1:0] base_q;
	logic [WIDTH-1:0] mask_q;
	logic             last_q;
	logic             err_q;

	logic [WIDTH-1:0] start_lo;
	logic [WIDTH-1:0] align_mask;
	logic [WIDTH:0]   span_len;
	logic [WIDTH:0]   span_smear;
	logic [WIDTH-1:0] size_mask;
	logic [WIDTH-1:0] blk_mask;
	logic [WIDTH-1:0] blk_end;

	assign start_lo = start_q[WIDTH-1:0];

	always_comb begin
		// low bits below the lowest set bit of start; all ones when start is zero
		align_mask = (start_lo & (~start_lo + 1'b1)) - 1'b1;
		span_len   = {1'b0, upper_q} - {1'b0, start_lo} + 1'b1;
		span_smear = span_len;
		for (int i = 1; i <= WIDTH; i = i * 2) begin
			span_smear = span_smear | (span_smear >> i);
		end
		// largest 2^k - 1 with 2^k not above the span length
		size_mask = span_smear[WIDTH:1];
		blk_mask  = align_mask & size_mask;
		// start is aligned, so the end is an OR
		blk_end   = start_lo | blk_mask;
	end

	assign status.bad  = (start_q > {1'b0, upper_q});
	assign status.last = (blk_end == upper_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			start_q <= {1'b0, lower_bound};
			upper_q <= upper_bound;
		end else if (cmd.emit_block) begin
			start_q <= {1'b0, blk_end} + 1'b1;
		end
		if (cmd.emit_block) begin
			base_q <= start_lo;
			mask_q <= blk_mask;
			last_q <= status.last;
			err_q  <= 1'b0;
		end else if (cmd.emit_err) begin
			base_q <= '0;
			mask_q <= '0;
			last_q <= 1'b0;
			err_q  <= 1'b1;
		end
	end

	assign base_value     = base_q;
	assign dont_care_mask = mask_q;
	assign last_block     = last_q;
	assign range_error    = err_q;

endmodule
`default_nettype wire

// File: src/rtps_ctrl.sv
`default_nettype none
module rtps_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output rtps_pkg::cmd_t      cmd,
	input  rtps_pkg::status_t   status
);

	typedef enum logic {
		ST_IDLE,
		ST_SPLIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load       = in_valid && in_ready;
		cmd.emit_block = (state_q == ST_SPLIT) && out_free && !status.bad;
		cmd.emit_err   = (state_q == ST_SPLIT) && out_free && status.bad;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (out_ready) out_valid_q <= 1'b0;
					if (in_valid) state_q <= ST_SPLIT;
				end
				ST_SPLIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						// error beat or final block ends the range
						if (status.bad || status.last) state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: src/range_to_ternary_prefix_split.sv
// The input beat loads the bounds and enters the split state; each block is then registered
// into the output. Throughput: one block per cycle while the output is not stalled; a range
// yields at most 2*WIDTH-2 blocks (30 at WIDTH 16) and holds off the input until it is done.
// The block-size step (span subtract, bit smear, end compare) sets the per-block cycle.
// Reset: arst_n clears the controller and output valid; bound and result registers
// are not reset.
`default_nettype none
module range_to_ternary_prefix_split #(
	parameter int WIDTH = rtps_pkg::WIDTH_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// lower_bound, upper_bound
	input  wire  [((2*WIDTH+7)/8)*8-1:0]     s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// base_value, dont_care_mask
	output logic [((2*WIDTH+7)/8)*8-1:0]     m_tdata,
	output logic                             m_tlast,
	// range_error
	output logic [0:0]                       m_tuser
);

	localparam int DATA_W = ((2*WIDTH+7)/8)*8;

	rtps_pkg::cmd_t    cmd;
	rtps_pkg::status_t status;
	logic [WIDTH-1:0]  base_value;
	logic [WIDTH-1:0]  dont_care_mask;
	logic              last_block;
	logic              range_error;

	rtps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.status    (status)
	);

	rtps_dp #(.WIDTH(WIDTH)) u_dp (
		.clk            (clk),
		.lower_bound    (s_tdata[WIDTH-1:0]),
		.upper_bound    (s_tdata[2*WIDTH-1:WIDTH]),
		.cmd            (cmd),
		.status         (status),
		.base_value     (base_value),
		.dont_care_mask (dont_care_mask),
		.last_block     (last_block),
		.range_error    (range_error)
	);

	assign m_tdata = DATA_W'({dont_care_mask, base_value});
	assign m_tlast = last_block;
	assign m_tuser = range_error;

endmodule
`default_nettype wire

// File: src/rtps_checker.sv
`default_nettype none
module rtps_checker #(
	parameter int WIDTH = rtps_pkg::WIDTH_DEF
) (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tready,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [((2*WIDTH+7)/8)*8-1:0]   m_tdata,
	input wire                           m_tlast,
	input wire [0:0]                     m_tuser
);

	logic [WIDTH-1:0] base;
	logic [WIDTH-1:0] mask;

	assign base = m_tdata[WIDTH-1:0];
	assign mask = m_tdata[2*WIDTH-1:WIDTH];

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
			&& $stable(m_tuser))
		else $error("output beat changed while stalled");

	// error beat carries no block
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == '0) && !m_tlast)
		else $error("error beat has nonzero fields");

	// mask is 2^k-1 and base is aligned to it
	a_block_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> ((mask & (mask + 1'b1)) == '0) && ((base & mask) == '0))
		else $error("block not aligned power of two");

	// no new range taken while a range is mid-split
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast && !m_tuser[0] |-> !s_tready)
		else $error("input ready during split");

endmodule

bind range_to_ternary_prefix_split rtps_checker #(.WIDTH(WIDTH)) u_rtps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
